### rtl/ldr_pkg.sv
// ----------------------------------------------------------------------------
// ldr_pkg
// Shared types, constants and helpers for the lens distortion remap block.
// ----------------------------------------------------------------------------
package ldr_pkg;

  typedef logic signed [31:0] q_t;
  typedef logic signed [63:0] wide_t;

  typedef enum logic [2:0] {
    REG_K1 = 3'd0,
    REG_K2 = 3'd1,
    REG_P1 = 3'd2,
    REG_P2 = 3'd3,
    REG_FX = 3'd4,
    REG_FY = 3'd5,
    REG_CX = 3'd6,
    REG_CY = 3'd7
  } reg_idx_t;

  localparam int DIV_STEPS  = 31;
  localparam int DIV_STAGES = DIV_STEPS + 2;
  localparam int POST_STAGES = 12;
  localparam int LAT = DIV_STAGES + POST_STAGES;

  localparam wide_t Q_MAX = 64'sd2147483647;
  localparam wide_t Q_ONE = 64'sd268435456;

  localparam q_t  K1_RST = -32'sd304307141;
  localparam q_t  K2_RST = 32'sd79412947;
  localparam q_t  P1_RST = 32'sd207865;
  localparam q_t  P2_RST = 32'sd18918;
  localparam logic [23:0] FX_RST = 24'd1878647;
  localparam logic [23:0] FY_RST = 24'd1873084;
  localparam logic [23:0] CX_RST = 24'd1504113;
  localparam logic [23:0] CY_RST = 24'd1017344;

  function automatic q_t sat_q(input wide_t v);
    q_t r;
    if (v > Q_MAX) r = q_t'(Q_MAX);
    else if (v < -Q_MAX) r = q_t'(-Q_MAX);
    else r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/ldr_div.sv
// ----------------------------------------------------------------------------
// ldr_div
// Pipelined normalizer: ((pix << 12) - c) * 2^28 / f, rounded toward zero,
// saturated to +-(2^31 - 1). One quotient bit per stage.
// ----------------------------------------------------------------------------
module ldr_div
  import ldr_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [11:0] pix,
  input  logic [23:0] c,
  input  logic [23:0] f,
  output q_t          q
);

  logic signed [25:0] diff;
  logic [23:0] mag;

  logic [23:0] m_r;
  logic        neg0_r, sat0_r, zero0_r;
  logic        neg_r [DIV_STEPS+1];
  logic        sat_r [DIV_STEPS+1];
  logic        zero_r [DIV_STEPS+1];
  logic [2:0]  lo_r [DIV_STEPS+1];
  logic [23:0] rem_r [DIV_STEPS+1];
  logic [30:0] quo_r [DIV_STEPS+1];
  q_t          q_r;

  assign diff = $signed({2'b00, pix, 12'b0}) - $signed({2'b00, c});
  assign mag  = diff[25] ? 24'(-diff) : diff[23:0];

  always_ff @(posedge clk) begin
    if (en) begin
      m_r     <= mag;
      neg0_r  <= diff[25];
      zero0_r <= (mag == 24'd0);
      sat0_r  <= (mag != 24'd0) && ({3'b000, mag} >= {f, 3'b000});
    end
  end

  assign neg_r[0]  = neg0_r;
  assign sat_r[0]  = sat0_r;
  assign zero_r[0] = zero0_r;
  assign lo_r[0]   = m_r[2:0];
  assign rem_r[0]  = {3'b000, m_r[23:3]};
  assign quo_r[0]  = '0;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic        din;
    logic [24:0] rem2;
    logic        ge;
    logic [23:0] rem_nxt;
    logic [23:0] rs_r;
    logic [30:0] qs_r;
    logic [2:0]  ls_r;
    logic        ns_r, ss_r, zs_r;

    if (DIV_STEPS - 1 - k >= 28) begin : g_hi
      assign din = lo_r[k][DIV_STEPS - 1 - k - 28];
    end else begin : g_lo
      assign din = 1'b0;
    end

    assign rem2    = {rem_r[k], din};
    assign ge      = rem2 >= {1'b0, f};
    assign rem_nxt = ge ? 24'(rem2 - {1'b0, f}) : rem2[23:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rs_r <= rem_nxt;
        qs_r <= {quo_r[k][29:0], ge};
        ls_r <= lo_r[k];
        ns_r <= neg_r[k];
        ss_r <= sat_r[k];
        zs_r <= zero_r[k];
      end
    end

    assign rem_r[k+1]  = rs_r;
    assign quo_r[k+1]  = qs_r;
    assign lo_r[k+1]   = ls_r;
    assign neg_r[k+1]  = ns_r;
    assign sat_r[k+1]  = ss_r;
    assign zero_r[k+1] = zs_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[DIV_STEPS]) q_r <= '0;
      else if (sat_r[DIV_STEPS]) q_r <= neg_r[DIV_STEPS] ? -q_t'(Q_MAX) : q_t'(Q_MAX);
      else if (neg_r[DIV_STEPS]) q_r <= -q_t'({1'b0, quo_r[DIV_STEPS]});
      else q_r <= q_t'({1'b0, quo_r[DIV_STEPS]});
    end
  end

  assign q = q_r;

endmodule

### rtl/lens_distortion_remap.sv
// ----------------------------------------------------------------------------
// lens_distortion_remap
// Brown-Conrady radial/tangential remap of output pixel to source pixel.
// ----------------------------------------------------------------------------
// One coordinate in per cycle, one result out per cycle while results are
// taken. The pipeline is the bit-per-stage normalizing divider (33 stages)
// followed by the multiply chain (12 stages).
// The whole pipeline advances together and holds while a result is not taken.
module lens_distortion_remap
  import ldr_pkg::*;
#(
  parameter int FRAME_COLS = 1024,
  parameter int FRAME_ROWS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_out_col,
  input  logic [11:0] in_out_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_src_col,
  output logic [11:0] out_src_row,
  output logic        out_inside_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic signed [18:0] COLS_L = 19'(FRAME_COLS);
  localparam logic signed [18:0] ROWS_L = 19'(FRAME_ROWS);

  q_t k1_r, k2_r, p1_r, p2_r;
  logic [23:0] fx_r, fy_r, cx_r, cy_r;
  reg_idx_t widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r <= K1_RST; k2_r <= K2_RST; p1_r <= P1_RST; p2_r <= P2_RST;
      fx_r <= FX_RST; fy_r <= FY_RST; cx_r <= CX_RST; cy_r <= CY_RST;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_K1: k1_r <= pwdata;
        REG_K2: k2_r <= pwdata;
        REG_P1: p1_r <= pwdata;
        REG_P2: p2_r <= pwdata;
        REG_FX: fx_r <= pwdata[23:0];
        REG_FY: fy_r <= pwdata[23:0];
        REG_CX: cx_r <= pwdata[23:0];
        REG_CY: cy_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_K1: prdata = k1_r;
      REG_K2: prdata = k2_r;
      REG_P1: prdata = p1_r;
      REG_P2: prdata = p2_r;
      REG_FX: prdata = {8'd0, fx_r};
      REG_FY: prdata = {8'd0, fy_r};
      REG_CX: prdata = {8'd0, cx_r};
      REG_CY: prdata = {8'd0, cy_r};
      default: prdata = '0;
    endcase
  end

  // pipeline control
  logic en;
  logic [LAT-1:0] vld_r;

  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  q_t x_d, y_d;

  ldr_div u_div_x (.clk(clk), .en(en), .pix(in_out_col), .c(cx_r), .f(fx_r), .q(x_d));
  ldr_div u_div_y (.clk(clk), .en(en), .pix(in_out_row), .c(cy_r), .f(fy_r), .q(y_d));

  wide_t xx_p_r, yy_p_r, xy_p_r;
  q_t    x1_r, y1_r, x2_r, y2_r, x3_r, y3_r, x4_r, y4_r, x5_r, y5_r, x6_r, y6_r, x7_r, y7_r;
  q_t    xx2_r, yy2_r, xy2_r, xx3_r, yy3_r, xy3_r, xy4_r;
  q_t    r2_3_r, tx4_r, ty4_r, r4_5_r, poly7_r, xd9_r, yd9_r;
  wide_t r4_p4_r, k1r2_p4_r, k1r2_5_r, k1r2_6_r;
  wide_t t1x_p5_r, t1y_p5_r, t2x_p5_r, t2y_p5_r;
  wide_t k2r4_p6_r, tx6_r, ty6_r, tx7_r, ty7_r, tx8_r, ty8_r;
  wide_t xp_p8_r, yp_p8_r, col_p10_r, row_p10_r, cxs10_r, cys10_r;
  logic signed [18:0] col11_r, row11_r;
  logic [11:0] src_col_r, src_row_r;
  logic inside_r;

  wide_t vc, vr;
  logic signed [18:0] colv, rowv;
  logic ins;

  assign vc   = col_p10_r + cxs10_r;
  assign vr   = row_p10_r + cys10_r;
  assign colv = vc[63] ? -19'(wide_t'(-vc) >>> 40) : 19'(vc >>> 40);
  assign rowv = vr[63] ? -19'(wide_t'(-vr) >>> 40) : 19'(vr >>> 40);
  assign ins  = (col11_r >= 0) && (col11_r < COLS_L) && (row11_r >= 0) && (row11_r < ROWS_L);

  always_ff @(posedge clk) begin
    if (en) begin
      xx_p_r <= x_d * x_d; yy_p_r <= y_d * y_d; xy_p_r <= x_d * y_d;
      x1_r <= x_d; y1_r <= y_d;

      xx2_r <= sat_q(xx_p_r >>> 28); yy2_r <= sat_q(yy_p_r >>> 28);
      xy2_r <= sat_q(xy_p_r >>> 28);
      x2_r <= x1_r; y2_r <= y1_r;

      r2_3_r <= sat_q(wide_t'(xx2_r) + wide_t'(yy2_r));
      xx3_r <= xx2_r; yy3_r <= yy2_r; xy3_r <= xy2_r;
      x3_r <= x2_r; y3_r <= y2_r;

      tx4_r <= sat_q(wide_t'(r2_3_r) + 2 * wide_t'(xx3_r));
      ty4_r <= sat_q(wide_t'(r2_3_r) + 2 * wide_t'(yy3_r));
      r4_p4_r <= r2_3_r * r2_3_r;
      k1r2_p4_r <= k1_r * r2_3_r;
      xy4_r <= xy3_r; x4_r <= x3_r; y4_r <= y3_r;

      r4_5_r <= sat_q(r4_p4_r >>> 28);
      k1r2_5_r <= k1r2_p4_r >>> 30;
      t1x_p5_r <= p1_r * xy4_r; t1y_p5_r <= p2_r * xy4_r;
      t2x_p5_r <= p2_r * tx4_r; t2y_p5_r <= p1_r * ty4_r;
      x5_r <= x4_r; y5_r <= y4_r;

      k2r4_p6_r <= k2_r * r4_5_r;
      k1r2_6_r <= k1r2_5_r;
      tx6_r <= (t1x_p5_r >>> 29) + (t2x_p5_r >>> 30);
      ty6_r <= (t1y_p5_r >>> 29) + (t2y_p5_r >>> 30);
      x6_r <= x5_r; y6_r <= y5_r;

      poly7_r <= sat_q(Q_ONE + k1r2_6_r + (k2r4_p6_r >>> 30));
      tx7_r <= tx6_r; ty7_r <= ty6_r; x7_r <= x6_r; y7_r <= y6_r;

      xp_p8_r <= x7_r * poly7_r; yp_p8_r <= y7_r * poly7_r;
      tx8_r <= tx7_r; ty8_r <= ty7_r;

      xd9_r <= sat_q((xp_p8_r >>> 28) + tx8_r);
      yd9_r <= sat_q((yp_p8_r >>> 28) + ty8_r);

      col_p10_r <= $signed({1'b0, fx_r}) * xd9_r;
      row_p10_r <= $signed({1'b0, fy_r}) * yd9_r;
      cxs10_r <= wide_t'({40'd0, cx_r}) <<< 28;
      cys10_r <= wide_t'({40'd0, cy_r}) <<< 28;

      col11_r <= colv; row11_r <= rowv;

      inside_r  <= ins;
      src_col_r <= ins ? col11_r[11:0] : 12'd0;
      src_row_r <= ins ? row11_r[11:0] : 12'd0;
    end
  end

  assign out_valid      = vld_r[LAT-1];
  assign out_src_col    = src_col_r;
  assign out_src_row    = src_row_r;
  assign out_inside_res = inside_r;

`ifndef ASSERT_OFF
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready) else $error("input taken during stall");
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_inside_res) |-> (out_src_col == 12'd0 && out_src_row == 12'd0))
    else $error("outside result has nonzero source");
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0]) else $error("accepted beat lost");
`endif

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// Lens distortion remap testbench
// Streams output-pixel coordinates through the remap block under random
// handshake pressure and checks every source coordinate and inside flag
// against a fixed-point model of the radial/tangential remap, across several
// calibration settings written over the APB port.
// ----------------------------------------------------------------------------
module tb
  import ldr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 1024;
  localparam int ROWS = 1024;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic        in_frame;
  } remap_t;

  class remap_scoreboard;
    logic signed [63:0] k1, k2, p1, p2, fx, fy, cx, cy;
    remap_t pending[$];
    int errors;

    function new();
      k1 = K1_RST; k2 = K2_RST; p1 = P1_RST; p2 = P2_RST;
      fx = FX_RST; fy = FY_RST; cx = CX_RST; cy = CY_RST;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_K1: k1 = $signed(v);
        REG_K2: k2 = $signed(v);
        REG_P1: p1 = $signed(v);
        REG_P2: p2 = $signed(v);
        REG_FX: fx = v[23:0];
        REG_FY: fy = v[23:0];
        REG_CX: cx = v[23:0];
        default: cy = v[23:0];
      endcase
    endfunction

    function logic signed [63:0] clamp(logic signed [63:0] v);
      if (v > Q_MAX) return Q_MAX;
      if (v < -Q_MAX) return -Q_MAX;
      return v;
    endfunction

    // arithmetic shift of a signed value is floor division
    function logic signed [63:0] fmul(logic signed [63:0] a, logic signed [63:0] b, int s);
      logic signed [63:0] p;
      p = a * b;
      return p >>> s;
    endfunction

    function logic signed [63:0] to_norm(logic [11:0] pix, logic signed [63:0] c,
                                         logic signed [63:0] f);
      logic signed [63:0] d;
      logic [63:0] m, q;
      d = $signed({40'd0, pix, 12'd0}) - c;
      m = d < 0 ? -d : d;
      if (f == 0) q = m != 0 ? Q_MAX : 0;
      else q = (m << 28) / f;
      if (q > Q_MAX) q = Q_MAX;
      return d < 0 ? -$signed(q) : $signed(q);
    endfunction

    function logic signed [63:0] to_pix(logic signed [63:0] f, logic signed [63:0] d,
                                        logic signed [63:0] c);
      logic signed [63:0] v;
      v = f * d + c * Q_ONE;
      if (v >= 0) return v >>> 40;
      return -((-v) >>> 40);
    endfunction

    function void note_coord(logic [11:0] oc, logic [11:0] orow);
      logic signed [63:0] x, y, xx, yy, xy, r2, r4, poly, xd, yd, c, r;
      remap_t e;
      x = to_norm(oc, cx, fx);
      y = to_norm(orow, cy, fy);
      xx = clamp(fmul(x, x, 28));
      yy = clamp(fmul(y, y, 28));
      xy = clamp(fmul(x, y, 28));
      r2 = clamp(xx + yy);
      r4 = clamp(fmul(r2, r2, 28));
      poly = clamp(Q_ONE + fmul(k1, r2, 30) + fmul(k2, r4, 30));
      xd = clamp(fmul(x, poly, 28) + fmul(p1, xy, 29) + fmul(p2, clamp(r2 + 2 * xx), 30));
      yd = clamp(fmul(y, poly, 28) + fmul(p2, xy, 29) + fmul(p1, clamp(r2 + 2 * yy), 30));
      c = to_pix(fx, xd, cx);
      r = to_pix(fy, yd, cy);
      e.in_frame = c >= 0 && c < COLS && r >= 0 && r < ROWS;
      e.col = e.in_frame ? c[11:0] : '0;
      e.row = e.in_frame ? r[11:0] : '0;
      pending.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_beat(logic [11:0] c, logic [11:0] r, logic ins);
      remap_t e;
      if (pending.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (c !== e.col) report($sformatf("src_col %0d exp %0d", c, e.col));
      if (r !== e.row) report($sformatf("src_row %0d exp %0d", r, e.row));
      if (ins !== e.in_frame) report($sformatf("inside %0b exp %0b", ins, e.in_frame));
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [11:0] in_out_col, in_out_row, out_src_col, out_src_row;
  logic out_inside_res;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  remap_scoreboard sb = new();
  int send_idle, recv_idle;

  lens_distortion_remap u_top (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("** lens_distortion_remap: FAILED **");
    $finish;
  end

  always @(posedge clk) if (rst_n) begin
    if (in_valid && in_ready) sb.note_coord(in_out_col, in_out_row);
    if (out_valid && out_ready) sb.check_beat(out_src_col, out_src_row, out_inside_res);
  end

  always @(negedge clk) out_ready <= rst_n && ($urandom_range(99) >= recv_idle);

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= 5'(idx) << 2; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic send_coord(logic [11:0] c, logic [11:0] r);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      in_valid <= 0;
    end
    @(negedge clk);
    in_valid <= 1; in_out_col <= c; in_out_row <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] v[8]);
    for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), v[i]);
  endtask

  task automatic random_phase(int n, int ci, int ri);
    send_idle = ci; recv_idle = ri;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) send_coord(12'($urandom), 12'($urandom));
      else send_coord(12'($urandom_range(1100)), 12'($urandom_range(1100)));
    end
    drain();
  endtask

  initial begin
    logic [31:0] cfg[8];
    rst_n = 0; in_valid = 0; in_out_col = 0; in_out_row = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    send_idle = 0; recv_idle = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed: field extremes and the principal point at reset calibration
    send_coord(0, 0); send_coord(4095, 4095); send_coord(0, 4095); send_coord(4095, 0);
    send_coord(367, 248); send_coord(512, 512); send_coord(1023, 1023);
    send_coord(12'hAAA, 12'h555); send_coord(12'h555, 12'hAAA);
    drain();
    // zero focal lengths and zero coefficients
    cfg = '{0, 0, 0, 0, 0, 0, 32'h00100000, 32'h00100000};
    write_all(cfg);
    send_coord(256, 256); send_coord(0, 0); send_coord(4095, 4095); send_coord(100, 300);
    drain();
    // extreme coefficients, max intrinsics
    cfg = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
            32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF};
    write_all(cfg);
    send_coord(0, 0); send_coord(4095, 4095); send_coord(2048, 100); send_coord(4000, 4095);
    drain();
    cfg = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1, 1, 0, 0};
    write_all(cfg);
    send_coord(0, 0); send_coord(1, 1); send_coord(4095, 0);
    drain();
    // calibration back, then random phases
    cfg = '{K1_RST, K2_RST, P1_RST, P2_RST,
            32'(FX_RST), 32'(FY_RST), 32'(CX_RST), 32'(CY_RST)};
    write_all(cfg);
    random_phase(550, 30, 46);
    cfg = '{$urandom_range(600000000) - 300000000, $urandom_range(200000000) - 100000000,
            $urandom_range(2000000) - 1000000, $urandom_range(2000000) - 1000000,
            $urandom_range(4000000, 500000), $urandom_range(4000000, 500000),
            $urandom_range(4194303), $urandom_range(4194303)};
    write_all(cfg);
    random_phase(550, 46, 30);
    cfg = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    write_all(cfg);
    random_phase(550, 0, 0);
    if (sb.errors == 0) $display("** lens_distortion_remap: PASSED **");
    else $display("** lens_distortion_remap: FAILED **");
    $finish;
  end
endmodule
